// ----- rtl/core/aes128_block_cipher_assert.svh -----
// Assertion macros used by the checker file aes_checker.
`ifndef AES128_BLOCK_CIPHER_ASSERT_SVH
`define AES128_BLOCK_CIPHER_ASSERT_SVH
// Assert that a condition implies something in the next cycle.
`define AES_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
// Assert that a condition implies something in the same cycle.
`define AES_ASSERT_NOW(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
`endif

// ----- rtl/core/aes_pkg.sv -----
// ---------------------------------------------------------------------------
// aes_pkg
// Constants, S-box tables and GF(2^8) helpers for the AES-128 core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package aes_pkg;

    localparam int unsigned ROUNDS      = 10;
    localparam int unsigned SCHED_WORDS = 4 * (ROUNDS + 1);
    localparam int unsigned KIDX_W      = 4;
    localparam int unsigned CFG_IDX_W   = 1;

    localparam logic [0:0] FUNC_ENC = 1'b0;
    localparam logic [0:0] FUNC_DEC = 1'b1;

    localparam logic [0:0] REG_KEY_HIGH = 1'b0;
    localparam logic [0:0] REG_KEY_LOW  = 1'b1;

    localparam logic [7:0] POLY_RED = 8'h1b;
    localparam logic [7:0] RCON_INIT = 8'h01;

    typedef logic [7:0] t_byte;

    // Round control passed from sequencer to datapath
    typedef struct packed {
        logic       load;
        logic       dec;
        logic       run;
        logic       last;
    } t_round_ctl;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
        8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
        8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
        8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
        8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
        8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
        8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
        8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
        8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
        8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
        8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
        8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
        8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
        8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
        8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
        8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16};

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
        8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
        8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
        8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
        8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
        8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
        8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
        8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
        8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
        8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
        8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
        8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
        8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
        8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
        8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D};

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? POLY_RED : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] v);
        return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
    endfunction

    // Forward MixColumns on one column (row 0 in bits 31:24)
    function automatic logic [31:0] mix_col(input logic [31:0] c);
        logic [7:0] a0, a1, a2, a3;
        a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
        return {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
    endfunction

    // Inverse MixColumns: pre-multiply by {04,00,05,00} then forward mix
    function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
        logic [7:0] a0, a1, a2, a3, u, v;
        a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
        u = xtime(xtime(a0 ^ a2));
        v = xtime(xtime(a1 ^ a3));
        return mix_col({a0 ^ u, a1 ^ v, a2 ^ u, a3 ^ v});
    endfunction

endpackage

// ----- rtl/core/aes_if.sv -----
// ---------------------------------------------------------------------------
// aes_if
// Valid/ready channels: data in, data out and key configuration writes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
interface aes_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [63:0] block_high;
    logic [63:0] block_low;
    modport source (output valid, func, block_high, block_low, input ready);
    modport sink   (input valid, func, block_high, block_low, output ready);
endinterface

interface aes_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_high;
    logic [63:0] result_low;
    modport source (output valid, result_high, result_low, input ready);
    modport sink   (input valid, result_high, result_low, output ready);
endinterface

interface aes_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/aes_keyexp.sv -----
// ---------------------------------------------------------------------------
// aes_keyexp
// Round-key store and iterative key expansion, one round key per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module aes_keyexp (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [127:0] i_key,
    input  logic [3:0]   i_rnd,
    output logic         o_busy,
    output logic [127:0] o_rkey
);
    logic [127:0] r_rkeys [aes_pkg::ROUNDS + 1];
    logic [aes_pkg::KIDX_W-1:0] r_idx, n_idx;
    logic         r_busy, n_busy;
    logic [7:0]   r_rc;
    logic [127:0] w_prev;
    logic [31:0]  w_p0, w_p1, w_p2, w_p3;
    logic [31:0]  w_n0, w_n1, w_n2, w_n3;

    assign o_busy = r_busy;
    assign w_prev = r_rkeys[r_idx - aes_pkg::KIDX_W'(1)];
    assign {w_p0, w_p1, w_p2, w_p3} = w_prev;
    assign w_n0 = w_p0 ^ aes_pkg::sub_word({w_p3[23:0], w_p3[31:24]}) ^ {r_rc, 24'h0};
    assign w_n1 = w_p1 ^ w_n0;
    assign w_n2 = w_p2 ^ w_n1;
    assign w_n3 = w_p3 ^ w_n2;

    always_comb begin
        n_idx  = r_idx;
        n_busy = r_busy;
        if (i_start) begin
            n_idx  = aes_pkg::KIDX_W'(1);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_idx = r_idx + aes_pkg::KIDX_W'(1);
            if (r_idx == aes_pkg::KIDX_W'(aes_pkg::ROUNDS)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= aes_pkg::KIDX_W'(1);
            r_busy <= 1'b1;
        end else begin
            r_idx  <= n_idx;
            r_busy <= n_busy;
        end
    end

    // Round keys and round constant; reset reloads the all-zero key
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_start) begin
            r_rkeys[0] <= i_rst_n ? i_key : 128'h0;
            r_rc       <= aes_pkg::RCON_INIT;
        end else if (r_busy) begin
            r_rkeys[r_idx] <= {w_n0, w_n1, w_n2, w_n3};
            r_rc           <= aes_pkg::xtime(r_rc);
        end
    end

    always_comb begin
        o_rkey = r_rkeys[i_rnd];
    end
endmodule

// ----- rtl/core/aes_round.sv -----
// ---------------------------------------------------------------------------
// aes_round
// Shared round unit and state register: one cipher round per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module aes_round (
    input  logic                i_clk,
    input  aes_pkg::t_round_ctl i_ctl,
    input  logic [127:0]        i_block,
    input  logic [127:0]        i_rkey,
    output logic [127:0]        o_state
);
    logic [127:0] r_state, n_state;
    logic [7:0]   w_in [16];
    logic [7:0]   w_sr [16];
    logic [7:0]   w_sb [16];
    logic [127:0] w_sbv, w_ak, w_mx;

    assign o_state = r_state;

    // Byte n at bits 127-8n; row n%4, column n/4
    always_comb begin
        for (int n = 0; n < 16; n++) begin
            w_in[n] = r_state[127-8*n -: 8];
        end
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                if (i_ctl.dec) begin
                    w_sr[r + 4*((c + r) & 3)] = w_in[r + 4*c];
                end else begin
                    w_sr[r + 4*c] = w_in[r + 4*((c + r) & 3)];
                end
            end
        end
        for (int n = 0; n < 16; n++) begin
            w_sb[n] = i_ctl.dec ? aes_pkg::INV_SBOX[w_sr[n]] : aes_pkg::SBOX[w_sr[n]];
            w_sbv[127-8*n -: 8] = w_sb[n];
        end
    end

    always_comb begin
        w_mx = '0;
        w_ak = w_sbv ^ i_rkey;
        for (int c = 0; c < 4; c++) begin
            if (i_ctl.dec) begin
                w_mx[127-32*c -: 32] = aes_pkg::inv_mix_col(w_ak[127-32*c -: 32]);
            end else begin
                w_mx[127-32*c -: 32] = aes_pkg::mix_col(w_sbv[127-32*c -: 32]) ^
                                       i_rkey[127-32*c -: 32];
            end
        end
        if (i_ctl.load) begin
            n_state = i_block ^ i_rkey;
        end else if (i_ctl.last) begin
            n_state = w_ak;
        end else begin
            n_state = w_mx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load || i_ctl.run) begin
            r_state <= n_state;
        end
    end
endmodule

// ----- rtl/core/aes128_block_cipher.sv -----
// Key add at input accept, then 10 rounds before the result is valid in S_OUT.
// The single round unit is reused per round; a new block is accepted only once the result is taken.
// Key write: starts the expansion, one round key per cycle; no input meanwhile.
// Reset: synchronous, active low; expands the all-zero key after reset.
// ---------------------------------------------------------------------------
// aes128_block_cipher
// AES-128 encrypt/decrypt with iterative round unit and stored key schedule.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module aes128_block_cipher (
    input  logic      i_clk,
    input  logic      i_rst_n,
    aes_in_if.sink    in_ch,
    aes_out_if.source out_ch,
    aes_cfg_if.sink   cfg_ch
);
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    t_state      r_st, n_st;
    logic [3:0]  r_cnt, n_cnt;
    logic        r_dec;
    logic [63:0] r_key_high, r_key_low;
    logic        w_kbusy, w_in_acc, w_cfg_acc;
    logic [3:0]  w_rnd;
    logic [127:0] w_rkey, w_state;
    aes_pkg::t_round_ctl w_ctl;

    assign w_in_acc  = in_ch.valid && in_ch.ready;
    assign w_cfg_acc = cfg_ch.valid && cfg_ch.ready;
    assign cfg_ch.ready = (r_st == S_IDLE);
    // Hold the input while a key write is offered
    assign in_ch.ready  = (r_st == S_IDLE) && !w_kbusy && !cfg_ch.valid;
    assign out_ch.valid = (r_st == S_OUT);
    assign out_ch.result_high = w_state[127:64];
    assign out_ch.result_low  = w_state[63:0];

    // Round number for key lookup: counts up for encrypt, down for decrypt
    always_comb begin
        if (r_st == S_RUN) begin
            w_rnd = r_dec ? 4'(4'(aes_pkg::ROUNDS) - r_cnt) : r_cnt;
        end else begin
            w_rnd = (in_ch.func == aes_pkg::FUNC_DEC) ? 4'(aes_pkg::ROUNDS) : 4'd0;
        end
        w_ctl.load  = w_in_acc;
        w_ctl.dec   = (r_st == S_IDLE) ? in_ch.func : r_dec;
        w_ctl.run   = (r_st == S_RUN);
        w_ctl.last  = (r_cnt == 4'(aes_pkg::ROUNDS));
    end

    always_comb begin
        n_st  = r_st;
        n_cnt = r_cnt;
        case (r_st)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_st  = S_RUN;
                    n_cnt = 4'd1;
                end
            end
            S_RUN: begin
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'(aes_pkg::ROUNDS)) begin
                    n_st = S_OUT;
                end
            end
            S_OUT: begin
                if (out_ch.ready) begin
                    n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st       <= S_IDLE;
            r_cnt      <= 4'd0;
            r_key_high <= 64'h0;
            r_key_low  <= 64'h0;
        end else begin
            r_st  <= n_st;
            r_cnt <= n_cnt;
            if (w_cfg_acc && cfg_ch.index == aes_pkg::REG_KEY_HIGH) begin
                r_key_high <= cfg_ch.data;
            end
            if (w_cfg_acc && cfg_ch.index == aes_pkg::REG_KEY_LOW) begin
                r_key_low <= cfg_ch.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_dec <= in_ch.func;
        end
    end

    aes_keyexp u_keyexp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cfg_acc),
        .i_key   ((cfg_ch.index == aes_pkg::REG_KEY_HIGH) ?
                  {cfg_ch.data, r_key_low} : {r_key_high, cfg_ch.data}),
        .i_rnd   (w_rnd),
        .o_busy  (w_kbusy),
        .o_rkey  (w_rkey)
    );

    aes_round u_round (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_block ({in_ch.block_high, in_ch.block_low}),
        .i_rkey  (w_rkey),
        .o_state (w_state)
    );
endmodule

// ----- rtl/core/aes_checker.sv -----
// ---------------------------------------------------------------------------
// aes_checker
// Port-level checks on the cipher handshakes, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "aes128_block_cipher_assert.svh"
module aes_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] out_high,
    input logic        cfg_valid,
    input logic        cfg_ready
);
    `AES_ASSERT_NEXT(a_no_in_after_accept, i_clk, i_rst_n, in_valid && in_ready, !in_ready, "input taken while busy")
    `AES_ASSERT_NOW(a_no_in_while_out, i_clk, i_rst_n, out_valid, !in_ready, "input ready with result pending")
    `AES_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_valid && !out_ready, out_valid && $stable(out_high), "result dropped or changed")
    `AES_ASSERT_NEXT(a_cfg_stall, i_clk, i_rst_n, cfg_valid && cfg_ready, !in_ready, "input ready during key expansion")
endmodule

bind aes128_block_cipher aes_checker u_aes_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_high  (out_ch.result_high),
    .cfg_valid (cfg_ch.valid),
    .cfg_ready (cfg_ch.ready)
);
